>>> sv/plmr_pkg.sv
// Shared types, widths and helpers for the pivot-move bead chain.
package plmr_pkg;

    localparam int COORD_W           = 24;
    localparam int ANGLE_W           = 18;
    localparam int ANGLE_FRAC        = 16;
    localparam int PIVOT_W           = 6;
    localparam int IN_TDATA_W        = 48;
    localparam int OUT_TDATA_W       = 64;
    localparam int DEF_CHAIN_LENGTH  = 6;
    localparam int DEF_FRACTION_BITS = 16;

    // Per-cycle commands shared by every bead cell
    typedef struct packed {
        logic shift;
        logic save;
        logic restore;
    } t_cell_ctl;

    // Reset x of one bead: index in fixed point, clipped to the coordinate range
    function automatic logic signed [COORD_W-1:0] init_x(input int idx, input int fb);
        longint v;
        longint hi;
        hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        v  = longint'(idx) <<< fb;
        if (v > hi) begin
            return COORD_W'(hi);
        end
        return COORD_W'(v);
    endfunction

endpackage

>>> sv/plmr_cell.sv
// One bead cell: live coordinates, a backup copy, and the link to its neighbor.
module plmr_cell
    import plmr_pkg::*;
#(
    parameter logic signed [COORD_W-1:0] INIT_X = '0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y
);

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_bx;
    logic signed [COORD_W-1:0] r_by;

    // Restore from backup, or take the neighbor's bead on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= INIT_X;
            r_y <= '0;
        end else if (i_ctl.restore) begin
            r_x <= r_bx;
            r_y <= r_by;
        end else if (i_ctl.shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    // Snapshot the bead at the start of a move
    always_ff @(posedge i_clk) begin
        if (i_ctl.save) begin
            r_bx <= r_x;
            r_by <= r_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

>>> sv/plmr_div.sv
// Division by a fixed divisor through its scaled reciprocal, four partial products accumulated in turn.
module plmr_div
    import plmr_pkg::*;
#(
    parameter int DIVISOR = DEF_CHAIN_LENGTH * DEF_CHAIN_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    output logic        o_busy,
    output logic [63:0] o_quot
);

    // Quotients of 2^32 and up saturate, so the rest is under DIVISOR * 2^32 < 2^44;
    // with DIVISOR up to 2^12 a 2^56 scale keeps the truncated product exact
    localparam int          RS    = 56;
    localparam longint      RECIP = ((longint'(1) <<< RS) + longint'(DIVISOR) - 1)
                                    / longint'(DIVISOR);
    localparam logic [53:0] MUL   = 54'(RECIP);
    localparam logic [63:0] LIMIT = 64'(DIVISOR) << 32;

    logic [43:0] r_n;
    logic [97:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_sat;
    logic [21:0] w_a;
    logic [26:0] w_b;
    logic [48:0] w_pp;
    logic [97:0] w_term;

    // Pick the dividend half and reciprocal half for this step
    assign w_a  = r_step[1] ? r_n[43:22] : r_n[21:0];
    assign w_b  = r_step[0] ? MUL[53:27] : MUL[26:0];
    assign w_pp = 49'(w_a) * 49'(w_b);

    // Align the partial product
    always_comb begin
        case (r_step)
            2'd0:    w_term = 98'(w_pp);
            2'd1:    w_term = 98'(w_pp) << 27;
            2'd2:    w_term = 98'(w_pp) << 22;
            default: w_term = 98'(w_pp) << 49;
        endcase
    end

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Latch the dividend, then accumulate one partial product per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_dividend[43:0];
            r_sat <= (i_dividend >= LIMIT);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_sat ? '1 : {32'b0, r_acc[RS+31:RS]};

endmodule

>>> sv/polymer_pivot_move.sv
// Top level of the pivot-move bead chain: ring of bead cells, head datapath, sequencer.
// The ring passes the beads one at a time past the single head unit, then the divider
// finishes the result; a restore after an overlap adds a state, and a bad pivot skips the
// rotation and overlap passes.
// One move is in flight at a time; the next is taken the cycle after the result is registered.
// Synchronous active-low reset puts the beads on the x axis and empties the output.
module polymer_pivot_move
    import plmr_pkg::*;
#(
    parameter int CHAIN_LENGTH  = DEF_CHAIN_LENGTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] pivot_index, [23:6] cos_angle, [41:24] sin_angle, zero above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] end_distance_sq, [63:32] gyration_value
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] accepted
    output logic [0:0]             m_axis_tuser
);

    localparam int IW        = $clog2(CHAIN_LENGTH);
    localparam int OUT_SHIFT = 2 * FRACTION_BITS - 16;
    localparam int DIVISOR   = CHAIN_LENGTH * CHAIN_LENGTH;
    localparam logic [IW-1:0] LAST      = IW'(CHAIN_LENGTH - 1);
    localparam logic [IW-1:0] LAST_REF  = IW'(CHAIN_LENGTH - 2);
    localparam logic [6:0]    MAX_PIVOT = 7'(CHAIN_LENGTH - 2);
    localparam logic [50:0]   ONE_SQ    = 51'(1) << (2 * FRACTION_BITS);
    localparam logic signed [44:0] HALF = 45'(1) << (ANGLE_FRAC - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SAVE   = 4'd1;
    localparam logic [3:0] S_ROT    = 4'd2;
    localparam logic [3:0] S_OVL    = 4'd3;
    localparam logic [3:0] S_REST   = 4'd4;
    localparam logic [3:0] S_END    = 4'd5;
    localparam logic [3:0] S_GYR    = 4'd6;
    localparam logic [3:0] S_DSTART = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // Sequencer state
    logic [3:0]    r_state;
    logic [1:0]    r_ph;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_a;
    logic          r_acc;
    logic          r_fail;
    logic          r_ovalid;

    // Move operands and head datapath
    logic [PIVOT_W-1:0]        r_pivot;
    logic signed [ANGLE_W-1:0] r_cos;
    logic signed [ANGLE_W-1:0] r_sin;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_refx;
    logic signed [COORD_W-1:0] r_refy;
    logic signed [24:0]        r_dx;
    logic signed [24:0]        r_dy;
    logic signed [42:0]        r_m1;
    logic signed [42:0]        r_m2;
    logic signed [42:0]        r_m3;
    logic signed [42:0]        r_m4;
    logic signed [44:0]        r_sx;
    logic signed [44:0]        r_sy;
    logic signed [49:0]        r_q1;
    logic signed [49:0]        r_q2;
    logic [50:0]               r_d;
    logic [50:0]               r_end;
    logic [63:0]               r_total;

    // Output register
    logic        r_out_acc;
    logic [31:0] r_out_end;
    logic [31:0] r_out_gyr;

    logic signed [COORD_W-1:0] w_x [CHAIN_LENGTH];
    logic signed [COORD_W-1:0] w_y [CHAIN_LENGTH];
    logic signed [COORD_W-1:0] w_hx;
    logic signed [COORD_W-1:0] w_hy;
    logic signed [COORD_W-1:0] w_tx;
    logic signed [COORD_W-1:0] w_ty;
    logic signed [COORD_W-1:0] w_ref_x;
    logic signed [COORD_W-1:0] w_ref_y;
    logic signed [28:0]        w_shx;
    logic signed [28:0]        w_shy;
    logic signed [29:0]        w_wx;
    logic signed [29:0]        w_wy;
    t_cell_ctl                 w_ctl;
    logic                      w_pass;
    logic                      w_bead_end;
    logic                      w_pass_end;
    logic                      w_act;
    logic                      w_rot_act;
    logic [6:0]                w_j7;
    logic [6:0]                w_p7;
    logic [6:0]                w_a7;
    logic                      w_pivot_ok;
    logic                      w_in_acc;
    logic                      w_div_start;
    logic                      w_div_busy;
    logic [63:0]               w_quot;
    logic [50:0]               w_end_sh;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [29:0] v);
        if (v[29:COORD_W-1] == {(31 - COORD_W){v[29]}}) begin
            return v[COORD_W-1:0];
        end else if (v[29]) begin
            return {1'b1, {(COORD_W - 1){1'b0}}};
        end
        return {1'b0, {(COORD_W - 1){1'b1}}};
    endfunction

    // Ring of bead cells; cell 0 faces the head, the last cell takes the head's output
    genvar k;
    generate
        for (k = 0; k < CHAIN_LENGTH; k++) begin : g_cell
            if (k == CHAIN_LENGTH - 1) begin : g_tail
                plmr_cell #(.INIT_X(init_x(k, FRACTION_BITS))) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl),
                    .i_x     (w_tx),
                    .i_y     (w_ty),
                    .o_x     (w_x[k]),
                    .o_y     (w_y[k])
                );
            end else begin : g_body
                plmr_cell #(.INIT_X(init_x(k, FRACTION_BITS))) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl),
                    .i_x     (w_x[k+1]),
                    .i_y     (w_y[k+1]),
                    .o_x     (w_x[k]),
                    .o_y     (w_y[k])
                );
            end
        end
    endgenerate

    // Divide the pair sum by the square of the length
    plmr_div #(.DIVISOR(DIVISOR)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_total >> OUT_SHIFT),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // Pass and bead timing
    assign w_hx       = w_x[0];
    assign w_hy       = w_y[0];
    assign w_pass     = r_state inside {S_ROT, S_OVL, S_END, S_GYR};
    assign w_bead_end = w_pass && (r_ph == 2'd3);
    assign w_pass_end = w_bead_end && (r_j == LAST);
    assign w_j7       = 7'(r_j);
    assign w_a7       = 7'(r_a);
    assign w_p7       = {1'b0, r_pivot};
    assign w_rot_act  = (w_j7 > w_p7);
    assign w_pivot_ok = (r_pivot != '0) && (w_p7 <= MAX_PIVOT);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_div_start = (r_state == S_DSTART);

    // Pick which beads count in a pair pass
    always_comb begin
        case (r_state)
            S_OVL:   w_act = (w_j7 > w_p7);
            S_END:   w_act = (r_j == LAST);
            S_GYR:   w_act = (r_j > r_a);
            default: w_act = 1'b0;
        endcase
    end

    // Rotated bead about the pivot, clipped to the coordinate range
    assign w_shx = r_sx[44:ANGLE_FRAC];
    assign w_shy = r_sy[44:ANGLE_FRAC];
    assign w_wx  = 30'(r_px) + 30'(w_shx);
    assign w_wy  = 30'(r_py) + 30'(w_shy);
    assign w_tx  = (r_state == S_ROT && w_rot_act) ? sat_coord(w_wx) : w_hx;
    assign w_ty  = (r_state == S_ROT && w_rot_act) ? sat_coord(w_wy) : w_hy;

    assign w_ref_x = (r_state == S_END) ? '0 : r_refx;
    assign w_ref_y = (r_state == S_END) ? '0 : r_refy;

    assign w_ctl.shift   = w_bead_end;
    assign w_ctl.save    = (r_state == S_SAVE);
    assign w_ctl.restore = (r_state == S_REST);

    // Sequence one move through the passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= '0;
            r_j      <= '0;
            r_a      <= '0;
            r_acc    <= 1'b0;
            r_fail   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_pass) begin
                r_ph <= r_ph + 2'd1;
            end
            if (w_bead_end) begin
                r_j <= (r_j == LAST) ? '0 : r_j + IW'(1);
            end
            if (r_state == S_OVL && w_bead_end && w_act && r_d < ONE_SQ) begin
                r_fail <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_SAVE;
                    end
                end
                S_SAVE: begin
                    r_acc   <= w_pivot_ok;
                    r_fail  <= 1'b0;
                    r_a     <= '0;
                    r_state <= w_pivot_ok ? S_ROT : S_END;
                end
                S_ROT: begin
                    if (w_pass_end) begin
                        r_state <= S_OVL;
                    end
                end
                S_OVL: begin
                    if (w_pass_end) begin
                        if (7'(w_a7 + 7'd1) == w_p7) begin
                            r_a     <= '0;
                            r_state <= (r_fail || (w_act && r_d < ONE_SQ)) ? S_REST : S_END;
                        end else begin
                            r_a <= r_a + IW'(1);
                        end
                    end
                end
                S_REST: begin
                    r_acc   <= 1'b0;
                    r_state <= S_END;
                end
                S_END: begin
                    if (w_pass_end) begin
                        r_a     <= '0;
                        r_state <= S_GYR;
                    end
                end
                S_GYR: begin
                    if (w_pass_end) begin
                        if (r_a == LAST_REF) begin
                            r_state <= S_DSTART;
                        end else begin
                            r_a <= r_a + IW'(1);
                        end
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Head datapath: four steps per bead
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pivot <= s_axis_tdata[5:0];
            r_cos   <= s_axis_tdata[23:6];
            r_sin   <= s_axis_tdata[41:24];
        end
        if (r_state == S_SAVE) begin
            r_total <= '0;
        end
        if (r_state == S_ROT) begin
            case (r_ph)
                2'd0: begin
                    if (w_j7 == w_p7) begin
                        r_px <= w_hx;
                        r_py <= w_hy;
                    end
                    r_dx <= 25'(w_hx) - 25'(r_px);
                    r_dy <= 25'(w_hy) - 25'(r_py);
                end
                2'd1: begin
                    r_m1 <= r_dx * r_cos;
                    r_m2 <= r_dy * r_sin;
                    r_m3 <= r_dy * r_cos;
                    r_m4 <= r_dx * r_sin;
                end
                2'd2: begin
                    r_sx <= r_m1 + r_m2 + HALF;
                    r_sy <= r_m3 - r_m4 + HALF;
                end
                default: begin
                end
            endcase
        end else if (w_pass) begin
            case (r_ph)
                2'd0: begin
                    if (r_j == r_a) begin
                        r_refx <= w_hx;
                        r_refy <= w_hy;
                    end
                    r_dx <= 25'(w_ref_x) - 25'(w_hx);
                    r_dy <= 25'(w_ref_y) - 25'(w_hy);
                end
                2'd1: begin
                    r_q1 <= r_dx * r_dx;
                    r_q2 <= r_dy * r_dy;
                end
                2'd2: begin
                    r_d <= {1'b0, r_q1} + {1'b0, r_q2};
                end
                default: begin
                    if (w_act && r_state == S_END) begin
                        r_end <= r_d;
                    end
                    if (w_act && r_state == S_GYR) begin
                        r_total <= r_total + 64'(r_d);
                    end
                end
            endcase
        end
    end

    // Load the result, saturated to 32 bits
    assign w_end_sh = r_end >> OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_out_acc <= r_acc;
            r_out_end <= (|w_end_sh[50:32]) ? 32'hFFFF_FFFF : w_end_sh[31:0];
            r_out_gyr <= (|w_quot[63:32]) ? 32'hFFFF_FFFF : w_quot[31:0];
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = {r_out_gyr, r_out_end};
    assign m_axis_tuser[0] = r_out_acc;

endmodule

>>> sv/plmr_checker.sv
// Port-level checks on the pivot-move block, bound to its top level.
module plmr_checker
    import plmr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // One move at a time: an input transaction closes the input side
    a_one_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a move is in flight");

    // A result never appears straight out of idle
    a_no_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result raised without a move");

endmodule

bind polymer_pivot_move plmr_checker u_plmr_checker (.*);
